/* rtl/core/cpt_pkg.sv */
// Package for the CPU capacity pressure tracker.
// Holds widths, register codes, reset values and the structs shared by the
// interfaces, the state memory, the divider and the top level.
package cpt_pkg;

	localparam int NUM_CPUS   = 64;
	localparam int CPU_AW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IDX_W      = 6;
	localparam int TIME_W     = 64;
	localparam int CAP_W      = 11;
	localparam int WIN_W      = 32;
	localparam int PCT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_W      = TIME_W;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int FRAC_SHIFT = 10;

	localparam logic [CAP_W-1:0] SCALE       = CAP_W'(1024);
	localparam logic [6:0]       PCT_SCALE   = 7'd100;
	localparam logic             ENABLE_RST  = 1'b1;
	localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(32000000);
	localparam logic [PCT_W-1:0] PCT_RST     = PCT_W'(117);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 2'd0,
		REG_WINDOW = 2'd1,
		REG_PCT    = 2'd2
	} cfg_reg_t;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_READ  = 9'b000000010,
		S_DELTA = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_DIV   = 9'b000010000,
		S_AVG   = 9'b000100000,
		S_BAL   = 9'b001000000,
		S_CMP   = 9'b010000000,
		S_HOLD  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] last_eval_time;
		logic [TIME_W-1:0] lost_at_eval;
		logic [TIME_W-1:0] offset_at_eval;
		logic [CAP_W-1:0]  avail_average;
		logic [CAP_W-1:0]  stored_balance_cap;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [CPU_AW-1:0] addr;
		entry_t            data;
	} mem_wr_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/cpt_if.sv */
// Channel interfaces of the CPU capacity pressure tracker.
// Item, result and configuration channels; widths come from cpt_pkg.
interface cpt_item_if;
	import cpt_pkg::*;
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    cpu_index;
	logic [TIME_W-1:0]   now_ns;
	logic [TIME_W-1:0]   lost_total_ns;
	logic [TIME_W-1:0]   clock_offset_ns;
	logic                demand;
	logic [CAP_W-1:0]    capacity;
	modport source(output valid, cpu_index, now_ns, lost_total_ns, clock_offset_ns, demand,
		capacity, input ready);
	modport sink(input valid, cpu_index, now_ns, lost_total_ns, clock_offset_ns, demand,
		capacity, output ready);
endinterface

interface cpt_result_if;
	import cpt_pkg::*;
	logic             valid;
	logic             ready;
	logic             updated;
	logic [CAP_W-1:0] balance_capacity;
	logic             capacity_reduced;
	modport source(output valid, updated, balance_capacity, capacity_reduced, input ready);
	modport sink(input valid, updated, balance_capacity, capacity_reduced, output ready);
endinterface

interface cpt_cfg_if;
	import cpt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/cpt_state_mem.sv */
// Per-CPU state memory: one write port, one registered read port.
// Entry layout comes from cpt_pkg; validity is tracked by the top level.
module cpt_state_mem (
	input  logic                       clk,
	input  cpt_pkg::mem_wr_t           wr,
	input  logic [cpt_pkg::CPU_AW-1:0] raddr,
	output cpt_pkg::entry_t            rdata
);
	import cpt_pkg::*;

	entry_t mem_q [NUM_CPUS];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/cpt_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Request and response structs come from cpt_pkg.
module cpt_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  cpt_pkg::div_req_t req,
	output cpt_pkg::div_rsp_t rsp
);
	import cpt_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     nq_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W:0]       rem_sh;
	logic [DIV_W:0]       diff;
	logic                 ge;

	assign rem_sh = {rem_q, nq_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = nq_q;

endmodule

/* rtl/core/cpu_capacity_pressure_tracker_top.sv */
// Top level of the CPU capacity pressure tracker: sequencer, configuration
// registers and per-CPU valid bits. Uses cpt_pkg, cpt_if, cpt_state_mem and
// cpt_divider.
//
// Usage: items arrive on the item channel, one result per item leaves on the
// result channel, and registers are written on the cfg channel (always
// ready; index 0 enable, 1 evaluation window, 2 imbalance percent).
// The block takes one item at a time. An item that does not evaluate goes
// from S_CHECK straight to S_CMP; an item that evaluates first waits in
// S_DIV on the restoring divider that forms the lost fraction.
// The next item can be accepted once the result is registered and the
// sequencer has passed from S_CMP through S_HOLD back to S_IDLE.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and works on the next item and waits only when that item's
// result is ready while the previous one has not been taken.
// Reset clears the valid bit of every CPU entry at once, so all entries read
// as zero afterward; no clearing pass is needed. Reset also restores the
// register defaults and empties the output register.
module cpu_capacity_pressure_tracker_top (
	input  logic        clk,
	input  logic        arst_n,
	cpt_cfg_if.sink     cfg,
	cpt_item_if.sink    item,
	cpt_result_if.source result
);
	import cpt_pkg::*;

	state_t            state_q, state_d;
	logic              enable_q;
	logic [WIN_W-1:0]  window_q;
	logic [PCT_W-1:0]  pct_q;
	logic [NUM_CPUS-1:0] valid_q;

	logic [CPU_AW-1:0] addr_q;
	logic              oor_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] lost_tot_q;
	logic [TIME_W-1:0] off_q;
	logic              demand_q;
	logic [CAP_W-1:0]  cap_q;

	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] lostd_q;
	logic [TIME_W-1:0] offadd_q;
	logic              vld_q;
	logic              eval_q;
	logic [CAP_W-1:0]  avg_q;
	logic [CAP_W-1:0]  bal_q;

	logic              out_valid_q;
	logic              out_updated_q;
	logic [CAP_W-1:0]  out_bal_q;
	logic              out_reduced_q;

	entry_t            rdata;
	entry_t            ent;
	logic              vld_rd;
	mem_wr_t           wr;
	div_req_t          dreq;
	div_rsp_t          drsp;

	logic              accept;
	logic              out_load;
	logic [WIN_W-1:0]  win_eff;
	logic              eval;
	logic [CAP_W-1:0]  frac;
	logic [CAP_W-1:0]  avail;
	logic [CAP_W+1:0]  ewma_sum;
	logic [2*CAP_W-1:0] prod;
	logic [18:0]       lhs;
	logic [18:0]       rhs;
	logic              reduced;

	assign accept    = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign vld_rd = valid_q[addr_q];
	assign ent    = vld_rd ? rdata : '0;

	assign win_eff = (window_q == '0) ? WIN_W'(1) : window_q;
	assign eval    = enable_q && demand_q && !oor_q &&
		(elapsed_q >= {{(TIME_W-WIN_W){1'b0}}, win_eff});

	assign frac     = (drsp.quotient > DIV_W'(SCALE)) ? SCALE : drsp.quotient[CAP_W-1:0];
	assign avail    = SCALE - frac;
	assign ewma_sum = ({2'b00, ent.avail_average} << 1) + {2'b00, ent.avail_average} +
		{2'b00, avail};

	assign prod = {{CAP_W{1'b0}}, cap_q} * {{CAP_W{1'b0}}, avg_q};

	assign lhs     = 19'(bal_q) * 19'(pct_q);
	assign rhs     = 19'(cap_q) * 19'(PCT_SCALE);
	assign reduced = enable_q && demand_q && (vld_q || eval_q) && (bal_q != '0) && (lhs < rhs);

	assign out_load = (state_q == S_CMP) && (!out_valid_q || result.ready);

	assign dreq.start    = (state_q == S_CHECK) && eval;
	assign dreq.dividend = (lostd_q + offadd_q) << FRAC_SHIFT;
	assign dreq.divisor  = elapsed_q;

	assign wr.we                      = (state_q == S_CMP) && eval_q;
	assign wr.addr                    = addr_q;
	assign wr.data.last_eval_time     = now_q;
	assign wr.data.lost_at_eval       = lost_tot_q;
	assign wr.data.offset_at_eval     = off_q;
	assign wr.data.avail_average      = avg_q;
	assign wr.data.stored_balance_cap = bal_q;

	cpt_state_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (addr_q),
		.rdata (rdata)
	);

	cpt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_READ;
			S_READ:  state_d = S_DELTA;
			S_DELTA: state_d = S_CHECK;
			S_CHECK: state_d = eval ? S_DIV : S_CMP;
			S_DIV:   if (drsp.done) state_d = S_AVG;
			S_AVG:   state_d = S_BAL;
			S_BAL:   state_d = S_CMP;
			S_CMP:   if (out_load) state_d = S_HOLD;
			S_HOLD:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			enable_q    <= ENABLE_RST;
			window_q    <= WINDOW_RST;
			pct_q       <= PCT_RST;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_ENABLE: enable_q <= cfg.data[0];
					REG_WINDOW: window_q <= cfg.data[WIN_W-1:0];
					REG_PCT:    pct_q    <= cfg.data[PCT_W-1:0];
					default:    ;
				endcase
			end
			if (wr.we) begin
				valid_q[addr_q] <= 1'b1;
			end
			priority if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q     <= CPU_AW'(item.cpu_index);
			oor_q      <= (32'(item.cpu_index) >= 32'(NUM_CPUS));
			now_q      <= item.now_ns;
			lost_tot_q <= item.lost_total_ns;
			off_q      <= item.clock_offset_ns;
			demand_q   <= item.demand;
			cap_q      <= item.capacity;
		end
		if (state_q == S_DELTA) begin
			elapsed_q <= now_q - ent.last_eval_time;
			lostd_q   <= lost_tot_q - ent.lost_at_eval;
			offadd_q  <= (off_q > ent.offset_at_eval) ? (off_q - ent.offset_at_eval) : '0;
			vld_q     <= vld_rd;
		end
		if (state_q == S_CHECK) begin
			eval_q <= eval;
			bal_q  <= oor_q ? '0 : ent.stored_balance_cap;
		end
		if (state_q == S_AVG) begin
			avg_q <= vld_q ? ewma_sum[CAP_W+1:2] : avail;
		end
		if (state_q == S_BAL) begin
			bal_q <= (prod[2*CAP_W-1:FRAC_SHIFT] == '0) ? CAP_W'(1) :
				prod[FRAC_SHIFT+CAP_W-1:FRAC_SHIFT];
		end
		if (out_load) begin
			out_updated_q <= eval_q;
			out_bal_q     <= bal_q;
			out_reduced_q <= reduced;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.updated          = out_updated_q;
	assign result.balance_capacity = out_bal_q;
	assign result.capacity_reduced = out_reduced_q;

endmodule

/* rtl/core/cpt_checker.sv */
// Port-level checker for the CPU capacity pressure tracker top level.
// Depends on cpt_pkg; attached to the top level by the bind at the end.
module cpt_prop_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_ready,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic                      updated,
	input logic [cpt_pkg::CAP_W-1:0] balance_capacity,
	input logic                      capacity_reduced
);
	import cpt_pkg::*;

	// A transaction on the item channel makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item channel ready right after a transaction");

	// No result can appear in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result appeared one cycle after an item transaction");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(balance_capacity) &&
		$stable(updated) && $stable(capacity_reduced))
		else $error("stalled result changed");

	// An evaluation always stores a balance capacity of at least one.
	a_updated_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && updated |-> balance_capacity != '0)
		else $error("evaluation produced zero balance capacity");

	a_reduced_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && capacity_reduced |-> balance_capacity != '0)
		else $error("reduced flag with zero balance capacity");

endmodule

bind cpu_capacity_pressure_tracker_top cpt_prop_checker u_cpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.updated          (result.updated),
	.balance_capacity (result.balance_capacity),
	.capacity_reduced (result.capacity_reduced)
);
